// ===== rtl/core/perspective_coord_warp_defines.svh =====
// assertion macros for the perspective coordinate warp
`ifndef PERSPECTIVE_COORD_WARP_DEFINES_SVH
`define PERSPECTIVE_COORD_WARP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pcw_pkg.sv =====
// types, constants and codes shared by the perspective coordinate warp
package pcw_pkg;

  localparam int unsigned COORD_W     = 20;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned PROD_W      = 52;
  localparam int unsigned SUM_W       = 53;
  localparam int unsigned DVS_W       = 52;
  localparam int unsigned DVD_W       = 80;
  localparam int unsigned QUO_W       = 33;
  localparam int unsigned MUL_W       = 64;
  localparam int unsigned MAG_W       = 63;
  localparam int unsigned NUM_DER     = 4;

  localparam int unsigned W_ONE_SHIFT = 44;
  localparam int unsigned OFS_SHIFT   = 16;
  localparam int unsigned NUM_SHIFT   = 28;
  localparam int unsigned COEFF_SHIFT = 28;
  localparam int unsigned DER_SHIFT   = 16;

  localparam int unsigned FRONT_LAT   = 4;
  localparam int unsigned DIV_LAT     = QUO_W + 3;
  localparam int unsigned DERIV_LAT   = 3;
  localparam int unsigned HOLD_LAT    = DERIV_LAT + DIV_LAT;
  localparam int unsigned TOTAL_LAT   = FRONT_LAT + DIV_LAT + HOLD_LAT + 1;

  localparam logic [QUO_W:0] LIM_NEG = (QUO_W + 1)'(64'd1 << (DATA_W - 1));
  localparam logic [QUO_W:0] LIM_POS = LIM_NEG - (QUO_W + 1)'(1);

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_COEFF_XU = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEFF_YU = 3'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET_U = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEFF_XV = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEFF_YV = 3'd4;
  localparam logic [IDX_W-1:0] REG_OFFSET_V = 3'd5;
  localparam logic [IDX_W-1:0] REG_PERSP_X  = 3'd6;
  localparam logic [IDX_W-1:0] REG_PERSP_Y  = 3'd7;

  // derivative lanes
  localparam int unsigned DER_UX = 0;
  localparam int unsigned DER_UY = 1;
  localparam int unsigned DER_VX = 2;
  localparam int unsigned DER_VY = 3;

  typedef struct packed {
    logic signed [DATA_W-1:0] coeff_x_to_u;
    logic signed [DATA_W-1:0] coeff_y_to_u;
    logic signed [DATA_W-1:0] offset_u;
    logic signed [DATA_W-1:0] coeff_x_to_v;
    logic signed [DATA_W-1:0] coeff_y_to_v;
    logic signed [DATA_W-1:0] offset_v;
    logic signed [DATA_W-1:0] persp_x;
    logic signed [DATA_W-1:0] persp_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    coeff_x_to_u: 32'sd16777216,
    coeff_y_to_u: 32'sd0,
    offset_u:     32'sd0,
    coeff_x_to_v: 32'sd0,
    coeff_y_to_v: 32'sd16777216,
    offset_v:     32'sd0,
    persp_x:      32'sd0,
    persp_y:      32'sd0
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] src_u;
    logic signed [DATA_W-1:0] src_v;
    logic signed [DATA_W-1:0] du_dx;
    logic signed [DATA_W-1:0] du_dy;
    logic signed [DATA_W-1:0] dv_dx;
    logic signed [DATA_W-1:0] dv_dy;
    logic        [1:0]        status;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic [DVD_W-1:0] dvd;
    logic [DVS_W-1:0] dvs;
    logic             neg;
  } div_req_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] quo;
    logic                     sat;
  } div_res_t;

  typedef struct packed {
    logic             zero;
    logic             wneg;
    logic [DVS_W-1:0] wmag;
  } side_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] src_u;
    logic signed [DATA_W-1:0] src_v;
    logic                     sat;
    logic                     zero;
  } hold_t;

endpackage

// ===== rtl/core/pcw_front.sv =====
// products, sums and magnitudes that feed the u and v dividers
module pcw_front import pcw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  req_t     req_i,
  input  cfg_t     cfg_i,
  output div_req_t u_req_o,
  output div_req_t v_req_o,
  output side_t    side_o
);

  localparam logic signed [SUM_W-1:0] W_ONE = SUM_W'(1) << W_ONE_SHIFT;

  logic [FRONT_LAT-1:0] vld_q;

  logic signed [COORD_W-1:0] x_q, y_q;
  logic signed [PROD_W-1:0]  pwx_q, pwy_q, pux_q, puy_q, pvx_q, pvy_q;
  logic signed [SUM_W-1:0]   w_q, nu_q, nv_q;
  logic signed [SUM_W-1:0]   wabs_s, uabs_s, vabs_s;
  logic [DVD_W-1:0]          udvd_q, vdvd_q;
  logic                      uneg_q, vneg_q;
  side_t                     side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FRONT_LAT-2:0], accept_i};
    end
  end

  assign wabs_s = w_q[SUM_W-1]  ? -w_q  : w_q;
  assign uabs_s = nu_q[SUM_W-1] ? -nu_q : nu_q;
  assign vabs_s = nv_q[SUM_W-1] ? -nv_q : nv_q;

  always_ff @(posedge clk_i) begin
    // input register
    x_q   <= req_i.pos_x;
    y_q   <= req_i.pos_y;
    // products
    pwx_q <= PROD_W'(cfg_i.persp_x)      * PROD_W'(x_q);
    pwy_q <= PROD_W'(cfg_i.persp_y)      * PROD_W'(y_q);
    pux_q <= PROD_W'(cfg_i.coeff_x_to_u) * PROD_W'(x_q);
    puy_q <= PROD_W'(cfg_i.coeff_y_to_u) * PROD_W'(y_q);
    pvx_q <= PROD_W'(cfg_i.coeff_x_to_v) * PROD_W'(x_q);
    pvy_q <= PROD_W'(cfg_i.coeff_y_to_v) * PROD_W'(y_q);
    // sums
    w_q   <= SUM_W'(pwx_q) + SUM_W'(pwy_q) + W_ONE;
    nu_q  <= SUM_W'(pux_q) + SUM_W'(puy_q) + (SUM_W'(cfg_i.offset_u) <<< OFS_SHIFT);
    nv_q  <= SUM_W'(pvx_q) + SUM_W'(pvy_q) + (SUM_W'(cfg_i.offset_v) <<< OFS_SHIFT);
    // sign and magnitude
    side_q.zero <= (w_q == '0);
    side_q.wneg <= w_q[SUM_W-1];
    side_q.wmag <= wabs_s[DVS_W-1:0];
    uneg_q      <= nu_q[SUM_W-1] ^ w_q[SUM_W-1];
    vneg_q      <= nv_q[SUM_W-1] ^ w_q[SUM_W-1];
    udvd_q      <= DVD_W'(uabs_s[DVS_W-1:0]) << NUM_SHIFT;
    vdvd_q      <= DVD_W'(vabs_s[DVS_W-1:0]) << NUM_SHIFT;
  end

  assign u_req_o = '{valid: vld_q[FRONT_LAT-1], dvd: udvd_q, dvs: side_q.wmag, neg: uneg_q};
  assign v_req_o = '{valid: vld_q[FRONT_LAT-1], dvd: vdvd_q, dvs: side_q.wmag, neg: vneg_q};
  assign side_o  = side_q;

endmodule

// ===== rtl/core/pcw_div.sv =====
// pipelined restoring divider, one quotient bit per stage, rounded and saturated
module pcw_div import pcw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_res_t res_o
);

  localparam int unsigned NSTG = QUO_W + 1;

  logic [NSTG-1:0]  vld_q, ovf_q, neg_q;
  logic [DVS_W-1:0] rem_q [NSTG];
  logic [DVS_W-1:0] dvs_q [NSTG];
  logic [QUO_W-1:0] low_q [NSTG];
  logic [QUO_W-1:0] quo_q [NSTG];

  logic [DVS_W:0]   shl_s  [QUO_W];
  logic [DVS_W-1:0] rem_s  [QUO_W];
  logic [QUO_W-1:0] qbit_s;

  logic [DVS_W-1:0] rem_init_s;
  logic             ovf_s;

  logic             rnd_s;
  logic             rv_q, rovf_q, rneg_q;
  logic [QUO_W:0]   rq_q;

  logic [QUO_W:0]   lim_s, mag_s, val_s;
  logic             sat_s;
  logic             ov_q, osat_q;
  logic [DATA_W-1:0] oquo_q;

  // dividend bits above the quotient window start the remainder
  assign rem_init_s = DVS_W'(req_i.dvd[DVD_W-1:QUO_W]);
  assign ovf_s      = rem_init_s >= req_i.dvs;

  always_comb begin
    for (int j = 0; j < QUO_W; j++) begin
      shl_s[j]  = {rem_q[j], low_q[j][QUO_W-1]};
      qbit_s[j] = shl_s[j] >= {1'b0, dvs_q[j]};
      rem_s[j]  = qbit_s[j] ? DVS_W'(shl_s[j] - {1'b0, dvs_q[j]}) : shl_s[j][DVS_W-1:0];
    end
  end

  assign rnd_s = {rem_q[NSTG-1], 1'b0} >= {1'b0, dvs_q[NSTG-1]};

  assign lim_s = rneg_q ? LIM_NEG : LIM_POS;
  assign sat_s = rovf_q || (rq_q > lim_s);
  assign mag_s = sat_s ? lim_s : rq_q;
  assign val_s = rneg_q ? -mag_s : mag_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], req_i.valid};
      rv_q  <= vld_q[NSTG-1];
      ov_q  <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= rem_init_s;
    dvs_q[0] <= req_i.dvs;
    low_q[0] <= req_i.dvd[QUO_W-1:0];
    quo_q[0] <= '0;
    ovf_q[0] <= ovf_s;
    neg_q[0] <= req_i.neg;
    for (int k = 1; k < NSTG; k++) begin
      rem_q[k] <= rem_s[k-1];
      dvs_q[k] <= dvs_q[k-1];
      low_q[k] <= {low_q[k-1][QUO_W-2:0], 1'b0};
      quo_q[k] <= {quo_q[k-1][QUO_W-2:0], qbit_s[k-1]};
      ovf_q[k] <= ovf_q[k-1];
      neg_q[k] <= neg_q[k-1];
    end
    // round to nearest, ties away from zero
    rq_q   <= {1'b0, quo_q[NSTG-1]} + (QUO_W + 1)'(rnd_s);
    rovf_q <= ovf_q[NSTG-1];
    rneg_q <= neg_q[NSTG-1];
    // clamp and apply sign
    oquo_q <= val_s[DATA_W-1:0];
    osat_q <= sat_s;
  end

  assign res_o = '{valid: ov_q, quo: signed'(oquo_q), sat: osat_q};

endmodule

// ===== rtl/core/pcw_deriv.sv =====
// numerators of the four derivatives, turned into divider requests
module pcw_deriv import pcw_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  div_res_t                  u_i,
  input  div_res_t                  v_i,
  input  side_t                     side_i,
  output div_req_t [NUM_DER-1:0]    req_o
);

  logic [DERIV_LAT-1:0] vld_q;

  logic signed [DATA_W-1:0] coeff_s [NUM_DER];
  logic signed [DATA_W-1:0] persp_s [NUM_DER];
  logic signed [DATA_W-1:0] src_s   [NUM_DER];

  logic signed [MUL_W-1:0] prod_q [NUM_DER];
  logic signed [MUL_W-1:0] num_q  [NUM_DER];
  logic signed [MUL_W-1:0] abs_s  [NUM_DER];
  logic [DVD_W-1:0]        dvd_q  [NUM_DER];
  logic [NUM_DER-1:0]      neg_q;
  side_t                   side_e_q, side_f_q;
  logic [DVS_W-1:0]        dvs_q;

  always_comb begin
    coeff_s[DER_UX] = cfg_i.coeff_x_to_u;
    coeff_s[DER_UY] = cfg_i.coeff_y_to_u;
    coeff_s[DER_VX] = cfg_i.coeff_x_to_v;
    coeff_s[DER_VY] = cfg_i.coeff_y_to_v;
    persp_s[DER_UX] = cfg_i.persp_x;
    persp_s[DER_UY] = cfg_i.persp_y;
    persp_s[DER_VX] = cfg_i.persp_x;
    persp_s[DER_VY] = cfg_i.persp_y;
    src_s[DER_UX]   = u_i.quo;
    src_s[DER_UY]   = u_i.quo;
    src_s[DER_VX]   = v_i.quo;
    src_s[DER_VY]   = v_i.quo;
    for (int k = 0; k < NUM_DER; k++) begin
      abs_s[k] = num_q[k][MUL_W-1] ? -num_q[k] : num_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DERIV_LAT-2:0], u_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    side_e_q <= side_i;
    side_f_q <= side_e_q;
    dvs_q    <= side_f_q.wmag;
    for (int k = 0; k < NUM_DER; k++) begin
      prod_q[k] <= MUL_W'(persp_s[k]) * MUL_W'(src_s[k]);
      num_q[k]  <= (MUL_W'(coeff_s[k]) <<< COEFF_SHIFT) - prod_q[k];
      neg_q[k]  <= num_q[k][MUL_W-1] ^ side_f_q.wneg;
      dvd_q[k]  <= DVD_W'(abs_s[k][MAG_W-1:0]) << DER_SHIFT;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_DER; k++) begin
      req_o[k] = '{valid: vld_q[DERIV_LAT-1], dvd: dvd_q[k], dvs: dvs_q, neg: neg_q[k]};
    end
  end

endmodule

// ===== rtl/core/perspective_coord_warp.sv =====
// top level of the perspective coordinate warp
// Maps one output pixel position (pos_x, pos_y, Q16.4) per request through a
// 3x3 homography whose denominator constant is one, and returns the source
// position (src_u, src_v, Q20.12) with its four screen-space derivatives
// (Q8.24). Quotients round to nearest, ties away from zero, and clamp to 32 bits
// with status 1; a zero denominator gives all-zero fields and status 2. One
// request is taken every clock (busy stays low) and each result comes out on res_o
// for one cycle with valid_o high; there is no back-pressure, so the receiver has
// to take every result as it appears. The path runs through two chained 36-stage
// dividers (33 quotient bits, one per stage, plus range check, rounding and
// clamp), four stages of products and sums in front, and three stages forming
// the derivative numerators. Write the registers only while no request is in
// flight.
`include "perspective_coord_warp_defines.svh"

module perspective_coord_warp import pcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  req_t              req_i,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_data_i,
  output logic              valid_o,
  output res_t              res_o
);

  cfg_t cfg_q;
  logic accept_s;

  div_req_t u_req_s, v_req_s;
  div_res_t u_res_s, v_res_s;
  side_t    side_s;

  div_req_t [NUM_DER-1:0] d_req_s;
  div_res_t               d_res_s [NUM_DER];

  // side data riding along the u/v dividers, then along the derivative path
  side_t side_dl_q [DIV_LAT];
  hold_t hold_dl_q [HOLD_LAT];
  hold_t hold_s, hold_end_s;

  logic valid_q;
  res_t res_q;
  logic sat_any_s;

  // no back-pressure: a new request enters every cycle
  assign busy     = 1'b0;
  assign accept_s = start && !busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COEFF_XU: cfg_q.coeff_x_to_u <= signed'(cfg_data_i);
        REG_COEFF_YU: cfg_q.coeff_y_to_u <= signed'(cfg_data_i);
        REG_OFFSET_U: cfg_q.offset_u     <= signed'(cfg_data_i);
        REG_COEFF_XV: cfg_q.coeff_x_to_v <= signed'(cfg_data_i);
        REG_COEFF_YV: cfg_q.coeff_y_to_v <= signed'(cfg_data_i);
        REG_OFFSET_V: cfg_q.offset_v     <= signed'(cfg_data_i);
        REG_PERSP_X:  cfg_q.persp_x      <= signed'(cfg_data_i);
        REG_PERSP_Y:  cfg_q.persp_y      <= signed'(cfg_data_i);
      endcase
    end
  end

  // w, u and v numerators
  pcw_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept_s),
    .req_i    (req_i),
    .cfg_i    (cfg_q),
    .u_req_o  (u_req_s),
    .v_req_o  (v_req_s),
    .side_o   (side_s)
  );

  // src_u and src_v quotients
  pcw_div u_div_u (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (u_req_s),
    .res_o  (u_res_s)
  );

  pcw_div u_div_v (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (v_req_s),
    .res_o  (v_res_s)
  );

  always_ff @(posedge clk_i) begin
    side_dl_q[0] <= side_s;
    for (int k = 1; k < DIV_LAT; k++) begin
      side_dl_q[k] <= side_dl_q[k-1];
    end
  end

  // derivative numerators use the clamped src_u / src_v
  pcw_deriv u_deriv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .u_i    (u_res_s),
    .v_i    (v_res_s),
    .side_i (side_dl_q[DIV_LAT-1]),
    .req_o  (d_req_s)
  );

  for (genvar g = 0; g < NUM_DER; g++) begin : g_ddiv
    pcw_div u_div_d (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (d_req_s[g]),
      .res_o  (d_res_s[g])
    );
  end

  assign hold_s = '{
    src_u: u_res_s.quo,
    src_v: v_res_s.quo,
    sat:   u_res_s.sat | v_res_s.sat,
    zero:  side_dl_q[DIV_LAT-1].zero
  };

  always_ff @(posedge clk_i) begin
    hold_dl_q[0] <= hold_s;
    for (int k = 1; k < HOLD_LAT; k++) begin
      hold_dl_q[k] <= hold_dl_q[k-1];
    end
  end

  assign hold_end_s = hold_dl_q[HOLD_LAT-1];
  assign sat_any_s  = hold_end_s.sat | d_res_s[DER_UX].sat | d_res_s[DER_UY].sat
                    | d_res_s[DER_VX].sat | d_res_s[DER_VY].sat;

  // output register: zero denominator wins over saturation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_res_s[DER_UX].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_end_s.zero) begin
      res_q.src_u  <= '0;
      res_q.src_v  <= '0;
      res_q.du_dx  <= '0;
      res_q.du_dy  <= '0;
      res_q.dv_dx  <= '0;
      res_q.dv_dy  <= '0;
      res_q.status <= STAT_ZERO;
    end else begin
      res_q.src_u  <= hold_end_s.src_u;
      res_q.src_v  <= hold_end_s.src_v;
      res_q.du_dx  <= d_res_s[DER_UX].quo;
      res_q.du_dy  <= d_res_s[DER_UY].quo;
      res_q.dv_dx  <= d_res_s[DER_VX].quo;
      res_q.dv_dy  <= d_res_s[DER_VY].quo;
      res_q.status <= sat_any_s ? STAT_SAT : STAT_OK;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  // every request comes out after the fixed latency
  `PCW_ASSERT_IMP(a_latency, accept_s, ##(TOTAL_LAT) valid_o, "request lost in pipeline")

  // a u/v quotient reaches the output after the derivative path
  `PCW_ASSERT_NEXT(a_uv_to_out, u_res_s.valid, ##(HOLD_LAT) valid_o, "derivative path misaligned")

  // zero denominator clears every field
  `PCW_ASSERT_IMP(a_zero_fields, valid_o && res_o.status == STAT_ZERO, res_o.src_u == '0 && res_o.src_v == '0 && res_o.du_dx == '0 && res_o.du_dy == '0 && res_o.dv_dx == '0 && res_o.dv_dy == '0, "zero denominator result not cleared")

  // a saturated status always shows a clamped field
  `PCW_ASSERT_IMP(a_sat_bound, valid_o && res_o.status == STAT_SAT, res_o.src_u == 32'sh7fffffff || res_o.src_u == 32'sh80000000 || res_o.src_v == 32'sh7fffffff || res_o.src_v == 32'sh80000000 || res_o.du_dx == 32'sh7fffffff || res_o.du_dx == 32'sh80000000 || res_o.du_dy == 32'sh7fffffff || res_o.du_dy == 32'sh80000000 || res_o.dv_dx == 32'sh7fffffff || res_o.dv_dx == 32'sh80000000 || res_o.dv_dy == 32'sh7fffffff || res_o.dv_dy == 32'sh80000000, "saturation flagged without clamped field")

endmodule
